// ===== hw/rtl/categorical_naive_bayes_classifier_macros.svh =====
// Assertion macros used by the checker of the classifier.
`ifndef CATEGORICAL_NAIVE_BAYES_CLASSIFIER_MACROS_SVH
`define CATEGORICAL_NAIVE_BAYES_CLASSIFIER_MACROS_SVH

// Property checked at every clock edge, reset included.
`define CNBC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is low.
`define CNBC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hw/rtl/cnbc_pkg.sv =====
package cnbc_pkg;

   // Fixed layout of the request payload.
   localparam int CELL_COUNT   = 9;
   localparam int CELL_BITS    = 2 * CELL_COUNT;
   localparam int SYMBOLS      = 3;
   localparam int POS_IDX_BITS = 4;

   // Request codes on req_type.
   localparam logic [1:0] REQ_CLEAR    = 2'd0;
   localparam logic [1:0] REQ_TRAIN    = 2'd1;
   localparam logic [1:0] REQ_CLASSIFY = 2'd2;

   // Cell codes and the symbols they map to.
   localparam logic [1:0] CODE_X    = 2'd1;
   localparam logic [1:0] CODE_O    = 2'd2;
   localparam logic [1:0] SYM_BLANK = 2'd0;
   localparam logic [1:0] SYM_X     = 2'd1;
   localparam logic [1:0] SYM_O     = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_TRAIN,
      OP_CLASSIFY
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [CELL_BITS-1:0] cells;
      logic                 label;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TR_READ,
      ST_TR_WRITE,
      ST_CL_READ,
      ST_CL_LOAD,
      ST_MUL,
      ST_CMP
   } state_type;

   // Symbol at position k; positions past the cells field are blank.
   function automatic logic [1:0] cell_symbol(input logic [CELL_BITS-1:0] cells,
                                              input logic [POS_IDX_BITS-1:0] k);
      logic [1:0] code;
      logic [1:0] sym;
      code = 2'd0;
      if (k < POS_IDX_BITS'(CELL_COUNT)) begin
         code = cells[2*k +: 2];
      end
      if (code == CODE_X) begin
         sym = SYM_X;
      end else if (code == CODE_O) begin
         sym = SYM_O;
      end else begin
         sym = SYM_BLANK;
      end
      return sym;
   endfunction

endpackage

// ===== hw/rtl/cnbc_ram.sv =====
module cnbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cnbc_front.sv =====
module cnbc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_type,
   input  logic [17:0]              req_cells,
   input  logic                     req_label,
   output logic                     busy,
   output logic                     q_valid,
   output cnbc_pkg::cmd_type        q_cmd,
   input  logic                     q_pop
);

   import cnbc_pkg::*;

   localparam logic [1:0] QDEPTH = 2'd2;

   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    decoded;
   logic       known;
   logic       push;

   always_comb begin
      decoded.cells = req_cells;
      decoded.label = req_label;
      decoded.op    = OP_CLEAR;
      known         = 1'b1;
      unique case (req_type)
         REQ_CLEAR:    decoded.op = OP_CLEAR;
         REQ_TRAIN:    decoded.op = OP_TRAIN;
         REQ_CLASSIFY: decoded.op = OP_CLASSIFY;
         default:      known = 1'b0;
      endcase
   end

   assign busy    = (count_ff == QDEPTH);
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = q_ff[rd_ptr_ff];

   // An unused request code is accepted and dropped here.
   assign push = start && !busy && known;

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_in[wr_ptr_ff] = decoded;
         wr_ptr_in       = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/cnbc_back.sv =====
module cnbc_back #(
   parameter int POSITIONS  = 9,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cnbc_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic              rsp_predicted,
   output logic              rsp_untrained
);

   import cnbc_pkg::*;

   localparam int CB    = COUNT_BITS;
   localparam int PB    = 2 * COUNT_BITS;
   localparam int LIMBS = 2 * POSITIONS - 1;
   localparam int DEPTH = POSITIONS * SYMBOLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(2 * POSITIONS);
   localparam int KW    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int SW    = (LIMBS > 1) ? $clog2(LIMBS) : 1;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [PW-1:0]    pass_ff, pass_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CB-1:0]    class_ff [2];
   logic [CB-1:0]    class_in [2];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             rvalid_ff, rvalid_in;
   logic [CB-1:0]    mpos_ff, mpos_in;
   logic [CB-1:0]    mneg_ff, mneg_in;
   logic [CB-1:0]    carry_pos_ff, carry_pos_in;
   logic [CB-1:0]    carry_neg_ff, carry_neg_in;
   logic [CB-1:0]    acc_pos_ff [LIMBS];
   logic [CB-1:0]    acc_pos_in [LIMBS];
   logic [CB-1:0]    acc_neg_ff [LIMBS];
   logic [CB-1:0]    acc_neg_in [LIMBS];
   logic             gt_ff, gt_in;
   logic             lt_ff, lt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_predicted_ff, rsp_predicted_in;
   logic             rsp_untrained_ff, rsp_untrained_in;

   logic [KW-1:0]    pos_idx;
   logic [1:0]       sym;
   logic [AW-1:0]    ram_addr;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [PB-1:0]    ram_wr_data;
   logic [PB-1:0]    ram_rd_data;
   logic [PB-1:0]    entry;
   logic [PB-1:0]    prod_pos;
   logic [PB-1:0]    prod_neg;
   logic             cur_gt;
   logic             cur_lt;

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Each entry holds the negative-class count in the low half and the
   // positive-class count in the high half.
   cnbc_ram #(
      .WIDTH(PB),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   assign pos_idx  = pass_ff[KW-1:0];
   assign sym      = cell_symbol(cmd_ff.cells, POS_IDX_BITS'(pos_idx));
   assign ram_addr = AW'(pos_idx) * AW'(SYMBOLS) + AW'(sym);
   assign entry    = rvalid_ff ? ram_rd_data : '0;

   // One limb of each running product per cycle; the carry stays below 2^CB.
   assign prod_pos = PB'(acc_pos_ff[0]) * PB'(mpos_ff) + PB'(carry_pos_ff);
   assign prod_neg = PB'(acc_neg_ff[0]) * PB'(mneg_ff) + PB'(carry_neg_ff);

   assign cur_gt = acc_pos_ff[LIMBS-1] > acc_neg_ff[LIMBS-1];
   assign cur_lt = acc_pos_ff[LIMBS-1] < acc_neg_ff[LIMBS-1];

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      pass_in          = pass_ff;
      step_in          = step_ff;
      class_in         = class_ff;
      valid_in         = valid_ff;
      rvalid_in        = rvalid_ff;
      mpos_in          = mpos_ff;
      mneg_in          = mneg_ff;
      carry_pos_in     = carry_pos_ff;
      carry_neg_in     = carry_neg_ff;
      acc_pos_in       = acc_pos_ff;
      acc_neg_in       = acc_neg_ff;
      gt_in            = gt_ff;
      lt_in            = lt_ff;
      rsp_valid_in     = 1'b0;
      rsp_predicted_in = rsp_predicted_ff;
      rsp_untrained_in = rsp_untrained_ff;
      q_pop            = 1'b0;
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;
      ram_wr_data      = entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cmd_in  = q_cmd;
               pass_in = '0;
               unique case (q_cmd.op)
                  OP_CLEAR: begin
                     valid_in    = '0;
                     class_in[0] = '0;
                     class_in[1] = '0;
                  end
                  OP_TRAIN: begin
                     class_in[q_cmd.label] = sat_inc(class_ff[q_cmd.label]);
                     state_in              = ST_TR_READ;
                  end
                  OP_CLASSIFY: begin
                     if (class_ff[0] == '0 || class_ff[1] == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_predicted_in = 1'b0;
                        rsp_untrained_in = 1'b1;
                     end else begin
                        for (int i = 0; i < LIMBS; i++) begin
                           acc_pos_in[i] = (i == 0) ? CB'(1) : '0;
                           acc_neg_in[i] = (i == 0) ? CB'(1) : '0;
                        end
                        state_in = ST_CL_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_TR_READ: begin
            ram_rd_en = 1'b1;
            rvalid_in = valid_ff[ram_addr];
            state_in  = ST_TR_WRITE;
         end

         ST_TR_WRITE: begin
            if (cmd_ff.label) begin
               ram_wr_data[PB-1:CB] = sat_inc(entry[PB-1:CB]);
            end else begin
               ram_wr_data[CB-1:0] = sat_inc(entry[CB-1:0]);
            end
            ram_wr_en          = 1'b1;
            valid_in[ram_addr] = 1'b1;
            if (pass_ff == PW'(POSITIONS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = ST_TR_READ;
            end
         end

         ST_CL_READ: begin
            ram_rd_en = 1'b1;
            rvalid_in = valid_ff[ram_addr];
            state_in  = ST_CL_LOAD;
         end

         ST_CL_LOAD: begin
            mpos_in      = entry[PB-1:CB];
            mneg_in      = entry[CB-1:0];
            step_in      = '0;
            carry_pos_in = '0;
            carry_neg_in = '0;
            state_in     = ST_MUL;
         end

         ST_MUL: begin
            // The product words rotate down one limb a cycle, so after a
            // full pass every limb is back in its place.
            for (int i = 0; i < LIMBS - 1; i++) begin
               acc_pos_in[i] = acc_pos_ff[i+1];
               acc_neg_in[i] = acc_neg_ff[i+1];
            end
            acc_pos_in[LIMBS-1] = prod_pos[CB-1:0];
            acc_neg_in[LIMBS-1] = prod_neg[CB-1:0];
            carry_pos_in        = prod_pos[PB-1:CB];
            carry_neg_in        = prod_neg[PB-1:CB];
            step_in             = step_ff + 1'b1;
            if (step_ff == SW'(LIMBS - 1)) begin
               step_in      = '0;
               carry_pos_in = '0;
               carry_neg_in = '0;
               if (pass_ff == PW'(2 * POSITIONS - 2)) begin
                  gt_in    = 1'b0;
                  lt_in    = 1'b0;
                  state_in = ST_CMP;
               end else begin
                  pass_in = pass_ff + 1'b1;
                  if (pass_ff < PW'(POSITIONS - 1)) begin
                     state_in = ST_CL_READ;
                  end else begin
                     // Prior terms: the positive side takes the negative
                     // sample count and the other way round.
                     mpos_in = class_ff[0];
                     mneg_in = class_ff[1];
                  end
               end
            end
         end

         ST_CMP: begin
            // Most significant limb first; the first difference decides.
            for (int i = LIMBS - 1; i > 0; i--) begin
               acc_pos_in[i] = acc_pos_ff[i-1];
               acc_neg_in[i] = acc_neg_ff[i-1];
            end
            step_in = step_ff + 1'b1;
            if (!gt_ff && !lt_ff) begin
               gt_in = cur_gt;
               lt_in = cur_lt;
            end
            if (step_ff == SW'(LIMBS - 1)) begin
               step_in          = '0;
               rsp_valid_in     = 1'b1;
               rsp_predicted_in = gt_ff || (!lt_ff && cur_gt);
               rsp_untrained_in = 1'b0;
               state_in         = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      pass_ff          <= pass_in;
      step_ff          <= step_in;
      rvalid_ff        <= rvalid_in;
      mpos_ff          <= mpos_in;
      mneg_ff          <= mneg_in;
      carry_pos_ff     <= carry_pos_in;
      carry_neg_ff     <= carry_neg_in;
      acc_pos_ff       <= acc_pos_in;
      acc_neg_ff       <= acc_neg_in;
      gt_ff            <= gt_in;
      lt_ff            <= lt_in;
      rsp_predicted_ff <= rsp_predicted_in;
      rsp_untrained_ff <= rsp_untrained_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         class_ff[0]  <= '0;
         class_ff[1]  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         class_ff     <= class_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_predicted = rsp_predicted_ff;
   assign rsp_untrained = rsp_untrained_ff;

endmodule

// ===== hw/rtl/categorical_naive_bayes_classifier.sv =====
// Two-class categorical naive Bayes classifier. A request is taken when start
// is high and busy is low; it enters a two-beat command queue, and busy is
// high only while that queue is full. Clear and train (one read-modify-write
// of the count memory per position) give no result. Classify with either
// class untrained is answered as soon as the executor takes it, and its
// result shows in the next cycle. A trained classify builds both exact
// products with one COUNT_BITS x COUNT_BITS multiplier per class, one limb per
// cycle over 2*POSITIONS-1 limbs for each of the 2*POSITIONS-1 factors,
// followed by a limb-serial compare; its result is registered after the last
// compare step. The result is shown for one cycle with rsp_valid and cannot
// be held off by the receiver. No clearing pass is needed after reset.
module categorical_naive_bayes_classifier #(
   parameter int POSITIONS  = 9,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [17:0] req_cells,
   input  logic        req_label,
   output logic        rsp_valid,
   output logic        rsp_predicted,
   output logic        rsp_untrained
);

   import cnbc_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   cnbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .req_cells (req_cells),
      .req_label (req_label),
      .busy      (busy),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   cnbc_back #(
      .POSITIONS  (POSITIONS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_predicted (rsp_predicted),
      .rsp_untrained (rsp_untrained)
   );

endmodule

// ===== hw/rtl/cnbc_checker.sv =====
`include "categorical_naive_bayes_classifier_macros.svh"

module cnbc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_predicted,
   input logic rsp_untrained
);

   // Nothing is answered in the cycle after reset.
   `CNBC_ASSERT(a_no_rsp_after_reset, clock,
                reset |=> !rsp_valid, "result after reset")

   // An untrained answer always predicts the negative class.
   `CNBC_ASSERT_RST(a_untrained_negative, clock, reset,
                    rsp_valid && rsp_untrained |-> !rsp_predicted,
                    "untrained result predicts positive")

   // The queue only fills on a beat that was taken.
   `CNBC_ASSERT_RST(a_busy_after_beat, clock, reset,
                    $rose(busy) |-> $past(start && !busy),
                    "busy rose without an accepted beat")

endmodule

bind categorical_naive_bayes_classifier cnbc_checker u_cnbc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_predicted (rsp_predicted),
   .rsp_untrained (rsp_untrained)
);
